// ===== rtl/uct_pkg.sv =====
// Shared types, constants and operation codes of the user credential table.
package uct_pkg;

  // Table geometry
  localparam int MAX_USERS  = 32;
  localparam int IDX_W      = $clog2(MAX_USERS);
  localparam int CNT_W      = $clog2(MAX_USERS + 1);
  localparam int RESULT_CAP = 32;
  localparam int ADM_W      = $clog2(RESULT_CAP + 1);

  // Id parts above this are rejected by add and update
  localparam logic [7:0] ID_LIMIT = 8'd99;

  // Status values with meaning at login and list
  localparam logic [1:0] PAID_STATUS  = 2'd1;
  localparam logic [1:0] ADMIN_STATUS = 2'd3;

  // Operation selector
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_UPDATE = 3'd1;
  localparam logic [2:0] FUNC_SEARCH = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_LOGIN  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;
  localparam logic [2:0] FUNC_LIST   = 3'd6;

  // Result codes
  localparam logic [2:0] CODE_OK         = 3'd0;
  localparam logic [2:0] CODE_BAD_ID     = 3'd1;
  localparam logic [2:0] CODE_ID_EXISTS  = 3'd2;
  localparam logic [2:0] CODE_NOT_FOUND  = 3'd3;
  localparam logic [2:0] CODE_FULL       = 3'd4;
  localparam logic [2:0] CODE_WRONG_PASS = 3'd5;
  localparam logic [2:0] CODE_GRANTED    = 3'd6;
  localparam logic [2:0] CODE_UNPAID     = 3'd7;

  // One stored user record
  typedef struct packed {
    logic [7:0] id_high;
    logic [7:0] id_low;
    logic [3:0] pass_digit0;
    logic [3:0] pass_digit1;
    logic [3:0] pass_digit2;
    logic [3:0] pass_digit3;
    logic [1:0] status;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Input beat
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] id_high;
    logic [7:0] id_low;
    logic [3:0] pass_digit0;
    logic [3:0] pass_digit1;
    logic [3:0] pass_digit2;
    logic [3:0] pass_digit3;
    logic [1:0] new_status;
  } uct_in_t;

  // Output beat
  typedef struct packed {
    logic [2:0] code;
    logic [1:0] user_status;
    logic [7:0] found_id_high;
    logic [7:0] found_id_low;
    logic       last;
  } uct_out_t;

  // Result handshake between the engine and the output stage
  typedef struct packed {
    logic     valid;
    uct_out_t data;
  } uct_res_t;

endpackage

// ===== rtl/uct_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module uct_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/uct_engine.sv =====
// Operation sequencer: scans, updates and compacts the record memory.
module uct_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uct_pkg::uct_in_t    in_data_i,
  output uct_pkg::uct_res_t   res_o,
  input  logic                res_ready_i
);
  import uct_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]       state_q, state_d;
  uct_in_t          req_q, req_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [ADM_W-1:0] nadm_q, nadm_d;
  logic             pend_v_q, pend_v_d;
  logic [7:0]       pend_h_q, pend_h_d;
  logic [7:0]       pend_l_q, pend_l_d;
  uct_out_t         res_q, res_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rec_t             ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  rec_t             rec;

  logic             is_list, match, bad_id, pass_ok, at_end;
  logic [CNT_W-1:0] idx_nxt;
  rec_t             new_rec;

  uct_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_USERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Record decode and compares
  always_comb begin
    rec     = rec_t'(ram_rdata);
    is_list = (req_q.func == FUNC_LIST);
    match   = (rec.id_high == req_q.id_high) && (rec.id_low == req_q.id_low);
    pass_ok = (rec.pass_digit0 == req_q.pass_digit0) &&
              (rec.pass_digit1 == req_q.pass_digit1) &&
              (rec.pass_digit2 == req_q.pass_digit2) &&
              (rec.pass_digit3 == req_q.pass_digit3);
    bad_id  = (in_data_i.id_high > ID_LIMIT) || (in_data_i.id_low > ID_LIMIT);
    idx_nxt = idx_q + CNT_W'(1);
    at_end  = (idx_q == count_q) || (is_list && (nadm_q == ADM_W'(RESULT_CAP)));
    new_rec.id_high     = req_q.id_high;
    new_rec.id_low      = req_q.id_low;
    new_rec.pass_digit0 = req_q.pass_digit0;
    new_rec.pass_digit1 = req_q.pass_digit1;
    new_rec.pass_digit2 = req_q.pass_digit2;
    new_rec.pass_digit3 = req_q.pass_digit3;
    new_rec.status      = req_q.new_status;
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    count_d    = count_q;
    idx_d      = idx_q;
    nadm_d     = nadm_q;
    pend_v_d   = pend_v_q;
    pend_h_d   = pend_h_q;
    pend_l_d   = pend_l_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q[IDX_W-1:0];
    ram_wdata  = new_rec;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[IDX_W-1:0];
    in_ready_o = 1'b0;
    res_o.valid = 1'b0;
    res_o.data  = res_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = in_data_i;
          idx_d    = '0;
          nadm_d   = '0;
          pend_v_d = 1'b0;
          res_d    = '{code: CODE_OK, user_status: 2'd0, found_id_high: 8'd0,
                       found_id_low: 8'd0, last: 1'b1};
          case (in_data_i.func)
            FUNC_CLEAR: begin
              count_d = '0;
              state_d = S_RESP;
            end
            FUNC_ADD, FUNC_UPDATE: begin
              if (bad_id) begin
                res_d.code = CODE_BAD_ID;
                state_d    = S_RESP;
              end else begin
                state_d = S_RD;
              end
            end
            FUNC_SEARCH, FUNC_DELETE, FUNC_LOGIN, FUNC_LIST: state_d = S_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Issue the next read, or close the scan
      S_RD: begin
        if (at_end) begin
          case (req_q.func)
            FUNC_LIST: begin
              if (pend_v_q) begin
                res_d = '{code: CODE_OK, user_status: ADMIN_STATUS,
                          found_id_high: pend_h_q, found_id_low: pend_l_q, last: 1'b1};
                state_d = S_RESP;
              end else begin
                state_d = S_IDLE;
              end
            end
            FUNC_ADD: begin
              if (count_q == CNT_W'(MAX_USERS)) begin
                res_d.code = CODE_FULL;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = count_q[IDX_W-1:0];
                count_d           = count_q + CNT_W'(1);
                res_d.user_status = req_q.new_status;
              end
              state_d = S_RESP;
            end
            default: begin
              res_d.code = CODE_NOT_FOUND;
              state_d    = S_RESP;
            end
          endcase
        end else begin
          ram_re  = 1'b1;
          state_d = S_CMP;
        end
      end

      // Evaluate the record fetched by the read issued in S_RD
      S_CMP: begin
        if (is_list) begin
          if (rec.status == ADMIN_STATUS) begin
            // An earlier admin goes out first; it is not the final beat
            res_o.valid = pend_v_q;
            res_o.data  = '{code: CODE_OK, user_status: ADMIN_STATUS,
                            found_id_high: pend_h_q, found_id_low: pend_l_q, last: 1'b0};
            if (!pend_v_q || res_ready_i) begin
              pend_v_d = 1'b1;
              pend_h_d = rec.id_high;
              pend_l_d = rec.id_low;
              nadm_d   = nadm_q + ADM_W'(1);
              idx_d    = idx_nxt;
              state_d  = S_RD;
            end
          end else begin
            idx_d   = idx_nxt;
            state_d = S_RD;
          end
        end else if (match) begin
          res_d.user_status = rec.status;
          state_d           = S_RESP;
          case (req_q.func)
            FUNC_ADD: res_d.code = CODE_ID_EXISTS;
            FUNC_UPDATE: begin
              ram_we            = 1'b1;
              res_d.user_status = req_q.new_status;
            end
            FUNC_DELETE: state_d = S_SH_RD;
            FUNC_LOGIN: begin
              if (!pass_ok) begin
                res_d.code = CODE_WRONG_PASS;
              end else if (rec.status == PAID_STATUS) begin
                res_d.code = CODE_GRANTED;
              end else begin
                res_d.code = CODE_UNPAID;
              end
            end
            default: res_d.code = CODE_OK;
          endcase
        end else begin
          idx_d   = idx_nxt;
          state_d = S_RD;
        end
      end

      // Delete: move each later record down one slot
      S_SH_RD: begin
        if (idx_nxt == count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_nxt[IDX_W-1:0];
          state_d   = S_SH_WR;
        end
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rec;
        idx_d     = idx_nxt;
        state_d   = S_SH_RD;
      end

      S_RESP: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      nadm_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      nadm_q   <= nadm_d;
      pend_v_q <= pend_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pend_h_q <= pend_h_d;
    pend_l_q <= pend_l_d;
    res_q    <= res_d;
  end

endmodule

// ===== rtl/user_credential_table.sv =====
// User credential table: a packed table of up to 32 user records (two-part id, four
// password digits, status) held in one synchronous RAM, serving add, update, search,
// delete, login, clear and list-admins requests one at a time. A request walks the
// table record by record, reading each record and then comparing it; delete then
// moves each later record down one slot with a read and a write, and clear or a
// rejected id skips the scan. List admins returns one beat per admin record, the
// final one flagged last, and none when there is no admin. Results pass through a
// one-beat output register, so the engine is not held by a slow consumer until a
// second result is ready.
module user_credential_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uct_pkg::uct_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uct_pkg::uct_out_t out_data_o
);
  import uct_pkg::*;

  uct_res_t res;
  logic     res_ready;
  logic     out_valid_q, out_valid_d;
  uct_out_t out_q;

  uct_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // Output register: takes a new beat when empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
